FILE: rtl/core/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies; imported by fbpa_div and fixed_block_pool_allocator_unit.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int COUNT_W    = 11;
    localparam int ADDR_W     = 32;
    localparam int CS_W       = 17;
    localparam int ALIGN_W    = 13;
    localparam int LOG2_W     = 4;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = LINK_W + CS_W;
    localparam int DIV_CNT_W  = $clog2(IDX_W + 1);

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_CHUNKS);

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd3;

    typedef struct packed {
        logic             done;
        logic             exact;
        logic [IDX_W-1:0] quotient;
    } div_out_t;

endpackage

FILE: rtl/core/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/fbpa_div.sv
// Restoring divider that turns a pool offset into a chunk index, one bit a cycle.
// Depends on fbpa_pkg; the quotient is known to fit in IDX_W bits.
`timescale 1ns / 1ps

module fbpa_div import fbpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [CS_W-1:0]   divisor,
    output div_out_t          result
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    dsh_reg, dsh_next;
    logic [IDX_W-1:0]     quo_reg, quo_next;
    logic [PROD_W:0]      trial;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(IDX_W);
            rem_next  = dividend;
            dsh_next  = PROD_W'(divisor) << (IDX_W - 1);
            quo_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                dsh_next = dsh_reg >> 1;
                if (!trial[PROD_W]) begin
                    rem_next = trial[PROD_W-1:0];
                    quo_next = {quo_reg[IDX_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[IDX_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign result.done     = busy_reg && (cnt_reg == '0);
    assign result.exact    = (rem_reg == '0);
    assign result.quotient = quo_reg;

endmodule

FILE: rtl/core/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator: LIFO free list of chunk indices in a link RAM.
// Accept to result valid: allocate EXEC, ALLOC, RESULT; rejected allocate, free of address
// zero and kind 3 EXEC, RESULT; free EXEC, CHECK, RESULT if out of range or misaligned,
// else also DIV (divider); rebuild EXEC, REBUILD (relink sweep), RESULT. One item at a
// time: the next word is taken the cycle after the result enters the output register.
// Reset empties the list and loads register defaults; the link RAM is not cleared.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit import fbpa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [CS_W-1:0]       s_req_size,
    input  logic [ALIGN_W-1:0]    s_req_align,
    input  logic [ADDR_W-1:0]     s_free_addr,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ADDR_W-1:0]     m_blk_addr,
    output logic [COUNT_W-1:0]    m_free_left
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_ALLOC   = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_REBUILD = 3'd5;
    localparam logic [2:0] S_RESULT  = 3'd6;

    // configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [CS_W-1:0]    blk_bytes_reg;
    logic [LOG2_W-1:0]  align_log2_reg;
    logic [COUNT_W-1:0] chunk_count_reg;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0]  sweep_reg, sweep_next;
    logic               m_valid_reg, m_valid_next;

    // item and working registers
    logic [KIND_W-1:0]   kind_reg;
    logic [CS_W-1:0]     size_reg;
    logic [ALIGN_W-1:0]  align_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]   diff_reg, diff_next;
    logic                below_reg, below_next;
    logic                misalign_reg, misalign_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_blk_addr_reg;
    logic [COUNT_W-1:0]  m_free_left_reg;

    // link RAM ports
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [LINK_W-1:0] ram_wdata, ram_rdata;

    logic              div_start;
    div_out_t          div_res;

    logic [COUNT_W-1:0] live;
    logic [CS_W-1:0]    align_bytes;
    logic [ADDR_W-1:0]  align_mask;
    logic [LINK_W-1:0]  mul_a;
    logic               accept, out_free;

    assign live        = (chunk_count_reg > COUNT_W'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS)
                                                                  : chunk_count_reg;
    assign align_bytes = CS_W'(1) << align_log2_reg;
    assign align_mask  = (ADDR_W'(1) << align_log2_reg) - ADDR_W'(1);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign mul_a       = (kind_reg == KIND_FREE) ? LINK_W'(live) : head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg        <= '0;
            blk_bytes_reg   <= CS_W'(8);
            align_log2_reg  <= LOG2_W'(3);
            chunk_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_POOL_BASE:   base_reg        <= cfg_wdata[ADDR_W-1:0];
                CFG_BLK_BYTES:   blk_bytes_reg   <= cfg_wdata[CS_W-1:0];
                CFG_ALIGN_LOG2:  align_log2_reg  <= cfg_wdata[LOG2_W-1:0];
                CFG_CHUNK_COUNT: chunk_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        m_valid_next    = m_valid_reg;
        prod_next       = prod_reg;
        diff_next       = diff_reg;
        below_next      = below_reg;
        misalign_next   = misalign_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = head_reg[IDX_W-1:0];
        div_start       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_OK;
                res_addr_next   = '0;
                prod_next       = PROD_W'(mul_a) * PROD_W'(blk_bytes_reg);
                case (kind_reg)
                    KIND_ALLOC: begin
                        if (size_reg > blk_bytes_reg ||
                            CS_W'(align_reg) > align_bytes) begin
                            res_status_next = ST_TOO_BIG;
                            state_next      = S_RESULT;
                        end else if (head_reg == NULL_LINK) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESULT;
                        end else begin
                            ram_re     = 1'b1;
                            state_next = S_ALLOC;
                        end
                    end
                    KIND_FREE: begin
                        diff_next     = addr_reg - base_reg;
                        below_next    = addr_reg < base_reg;
                        misalign_next = (addr_reg & align_mask) != '0;
                        state_next    = (addr_reg == '0) ? S_RESULT : S_CHECK;
                    end
                    KIND_REBUILD: begin
                        sweep_next = '0;
                        state_next = S_REBUILD;
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_ALLOC: begin
                // pop: the link of the old head becomes the new head
                head_next     = ram_rdata;
                count_next    = count_reg - COUNT_W'(1);
                res_addr_next = base_reg + ADDR_W'(prod_reg);
                state_next    = S_RESULT;
            end
            S_CHECK: begin
                if (blk_bytes_reg == '0 || below_reg || misalign_reg ||
                    diff_reg >= ADDR_W'(prod_reg)) begin
                    res_status_next = ST_BAD_FREE;
                    state_next      = S_RESULT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (div_res.exact) begin
                        // push the freed chunk on top
                        ram_we     = 1'b1;
                        ram_waddr  = div_res.quotient;
                        ram_wdata  = head_reg;
                        head_next  = LINK_W'(div_res.quotient);
                        count_next = count_reg + COUNT_W'(1);
                    end else begin
                        res_status_next = ST_BAD_FREE;
                    end
                    state_next = S_RESULT;
                end
            end
            S_REBUILD: begin
                if (sweep_reg == LINK_W'(live)) begin
                    head_next  = (live == '0) ? NULL_LINK : LINK_W'(live) - LINK_W'(1);
                    count_next = live;
                    state_next = S_RESULT;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = sweep_reg[IDX_W-1:0];
                    ram_wdata  = (sweep_reg == '0) ? NULL_LINK : sweep_reg - LINK_W'(1);
                    sweep_next = sweep_reg + LINK_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NULL_LINK;
            count_reg   <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            kind_reg  <= s_kind;
            size_reg  <= s_req_size;
            align_reg <= s_req_align;
            addr_reg  <= s_free_addr;
        end
        prod_reg       <= prod_next;
        diff_reg       <= diff_next;
        below_reg      <= below_next;
        misalign_reg   <= misalign_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        if (state_reg == S_RESULT && out_free) begin
            m_status_reg    <= res_status_reg;
            m_blk_addr_reg  <= res_addr_reg;
            m_free_left_reg <= count_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_blk_addr  = m_blk_addr_reg;
    assign m_free_left = m_free_left_reg;

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_CHUNKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_reg[PROD_W-1:0]),
        .divisor  (blk_bytes_reg),
        .result   (div_res)
    );

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word did not start execution");

    a_alloc_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ALLOC |-> head_reg != NULL_LINK)
        else $error("pop from an empty list");

    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_DIV || state_reg == S_REBUILD))
        else $error("link RAM written outside push or relink");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REBUILD |-> sweep_reg <= LINK_W'(live))
        else $error("relink sweep ran past the live chunks");

    a_result_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not moved to the output register");
`endif

endmodule
